### src/wma_pkg.sv
package wma_pkg;

    // Width of the window length register and of the held-sample count.
    localparam int LEN_W = 7;

    // Sequencer commands to the sample ring.
    typedef struct packed {
        logic clear;   // restart averaging (configuration write)
        logic rd_en;   // fetch the entry about to be overwritten
        logic upd_en;  // store the new sample, update sum and counters
    } ring_ctl_t;

    // Status of the serial divider.
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

### src/wma_sample_if.sv
interface wma_sample_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

### src/wma_result_if.sv
interface wma_result_if #(
    parameter int SAMPLE_BITS = 16
);
    import wma_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] average;
    logic [LEN_W-1:0]              samples_held;
    logic                          window_full;

    modport source (output valid, output average, output samples_held,
                    output window_full, input ready);
    modport sink   (input valid, input average, input samples_held,
                    input window_full, output ready);
endinterface

### src/wma_ring.sv
module wma_ring #(
    parameter int SAMPLE_BITS = 16,
    parameter int DEPTH       = 64,
    parameter int IDX_W       = 6,
    parameter int SUM_W       = 22
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  wma_pkg::ring_ctl_t            ctl,
    input  logic [wma_pkg::LEN_W-1:0]     len,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    output logic signed [SUM_W-1:0]       sum,
    output logic [wma_pkg::LEN_W-1:0]     fill
);
    import wma_pkg::*;

    logic signed [SAMPLE_BITS-1:0] mem [DEPTH];
    logic signed [SAMPLE_BITS-1:0] old_reg;

    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic [IDX_W-1:0]        slot;
    logic [LEN_W-1:0]        fill_reg, fill_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic                    full;

    // Wrap a stale index back to the start of the ring.
    assign slot = (LEN_W'(idx_reg) >= len) ? '0 : idx_reg;
    assign full = (fill_reg >= len);

    always_comb
    begin
        idx_next  = idx_reg;
        fill_next = fill_reg;
        sum_next  = sum_reg;
        if (ctl.clear)
        begin
            idx_next  = '0;
            fill_next = '0;
            sum_next  = '0;
        end
        else if (ctl.upd_en)
        begin
            // Drop the overwritten sample once the window is full.
            sum_next = sum_reg + SUM_W'(sample)
                       - (full ? SUM_W'(old_reg) : SUM_W'(0));
            if (!full)
                fill_next = fill_reg + LEN_W'(1);
            idx_next = (LEN_W'(slot) + LEN_W'(1) >= len) ? '0 : slot + IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= '0;
            fill_reg <= '0;
            sum_reg  <= '0;
        end
        else
        begin
            idx_reg  <= idx_next;
            fill_reg <= fill_next;
            sum_reg  <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
            old_reg <= mem[slot];
        if (ctl.upd_en)
            mem[slot] <= sample;
    end

    assign sum  = sum_reg;
    assign fill = fill_reg;

endmodule

### src/wma_div.sv
module wma_div #(
    parameter int SAMPLE_BITS = 16,
    parameter int SUM_W       = 22
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic signed [SUM_W-1:0]       dividend,
    input  logic [wma_pkg::LEN_W-1:0]     divisor,
    output logic signed [SAMPLE_BITS-1:0] quotient,
    output wma_pkg::div_stat_t            stat
);
    import wma_pkg::*;

    localparam int CNT_W = $clog2(SUM_W + 1);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg;
    logic             neg_reg;
    logic [SUM_W-1:0] quo_reg, quo_next;
    logic [LEN_W-1:0] rem_reg, rem_next;
    logic [SUM_W-1:0] dvd_u;
    logic [SUM_W-1:0] mag;
    logic [LEN_W:0]   trial;
    logic [LEN_W:0]   diff;
    logic             ge;
    logic [SUM_W-1:0] signed_quo;

    assign dvd_u = dividend;
    assign mag   = dvd_u[SUM_W-1] ? (~dvd_u + SUM_W'(1)) : dvd_u;

    // One restoring step: shift in the next dividend bit, subtract if it fits.
    assign trial = {rem_reg, quo_reg[SUM_W-1]};
    assign diff  = trial - {1'b0, divisor};
    assign ge    = (trial >= {1'b0, divisor});

    always_comb
    begin
        cnt_next = cnt_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        if (start)
        begin
            cnt_next = CNT_W'(SUM_W);
            quo_next = mag;
            rem_next = '0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
            quo_next = {quo_reg[SUM_W-2:0], ge};
            rem_next = ge ? diff[LEN_W-1:0] : trial[LEN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= !start && (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start)
            neg_reg <= dvd_u[SUM_W-1];
    end

    // Restore the sign; truncation toward zero follows from the magnitude form.
    assign signed_quo = neg_reg ? (~quo_reg + SUM_W'(1)) : quo_reg;
    assign quotient   = signed_quo[SAMPLE_BITS-1:0];

    assign stat.busy = (cnt_reg != '0);
    assign stat.done = done_reg;

endmodule

### src/windowed_moving_average.sv
// Windowed moving average. Each sample transaction writes one signed sample
// into a ring of the last window_len samples and yields one result
// transaction: the mean of the samples held (truncated toward zero), how many
// samples that mean covers, and whether the window has filled. A running sum
// is kept, so the only long operation per sample is one division, done by a
// serial restoring divider at one quotient bit per cycle. The sample port is
// not ready while a sample is in flight. A finished result waits in an
// output register, so the next sample is taken while the previous result is
// still unclaimed. The user must write window_len through
// cfg_wr_en/cfg_wr_data only while the block is idle; the block itself does
// not enforce this. Every write restarts averaging with an empty ring. A
// length of zero acts as one, a length above MAX_WINDOW acts as MAX_WINDOW.
// The ring is not cleared after reset: no entry's old value is used before
// it is written.
module windowed_moving_average #(
    parameter int MAX_WINDOW  = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic [wma_pkg::LEN_W-1:0]    cfg_wr_data,
    wma_sample_if.sink                   sample_ch,
    wma_result_if.source                 result_ch
);
    import wma_pkg::*;

    // The length register is 7 bits wide, so no window can exceed 127.
    localparam int EFF_MAX   = (MAX_WINDOW < 127) ? MAX_WINDOW : 127;
    localparam int IDX_W     = (EFF_MAX > 1) ? $clog2(EFF_MAX) : 1;
    localparam int SUM_W     = SAMPLE_BITS + $clog2(EFF_MAX);
    localparam int LEN_RESET = (EFF_MAX < 64) ? EFF_MAX : 64;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_UPD   = 5'b00010,
        S_START = 5'b00100,
        S_DIV   = 5'b01000,
        S_OUT   = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [LEN_W-1:0]              len_reg, len_next;
    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic                          out_valid_reg, out_valid_next;
    logic signed [SAMPLE_BITS-1:0] average_reg;
    logic [LEN_W-1:0]              held_reg;
    logic                          full_reg;

    logic                          accept;
    logic                          load_out;
    ring_ctl_t                     ring_ctl;
    div_stat_t                     div_stat;
    logic signed [SUM_W-1:0]       sum;
    logic [LEN_W-1:0]              fill;
    logic signed [SAMPLE_BITS-1:0] quotient;

    assign sample_ch.ready = (state_reg == S_IDLE);
    assign accept          = sample_ch.valid && (state_reg == S_IDLE);

    // Load the result once the output register is free or being emptied.
    assign load_out = (state_reg == S_OUT) && (!out_valid_reg || result_ch.ready);

    // Clamp the written length into the range the ring supports.
    always_comb
    begin
        len_next = len_reg;
        if (cfg_wr_en)
        begin
            if (cfg_wr_data == '0)
                len_next = LEN_W'(1);
            else if (int'(cfg_wr_data) > EFF_MAX)
                len_next = LEN_W'(EFF_MAX);
            else
                len_next = cfg_wr_data;
        end
    end

    // Sequencer: fetch old entry, update ring and sum, divide, present.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_UPD;
            end
            S_UPD:   state_next = S_START;
            S_START: state_next = S_DIV;
            S_DIV:
            begin
                if (div_stat.done)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                if (load_out)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && result_ch.ready)
            out_valid_next = 1'b0;
        if (load_out)
            out_valid_next = 1'b1;
    end

    assign ring_ctl.clear  = cfg_wr_en;
    assign ring_ctl.rd_en  = accept;
    assign ring_ctl.upd_en = (state_reg == S_UPD);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            len_reg       <= LEN_W'(LEN_RESET);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            sample_reg <= sample_ch.sample;
        if (load_out)
        begin
            average_reg <= quotient;
            held_reg    <= fill;
            full_reg    <= (fill == len_reg);
        end
    end

    wma_ring #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .DEPTH       (EFF_MAX),
        .IDX_W       (IDX_W),
        .SUM_W       (SUM_W)
    ) u_ring (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ring_ctl),
        .len    (len_reg),
        .sample (sample_reg),
        .sum    (sum),
        .fill   (fill)
    );

    wma_div #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .SUM_W       (SUM_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == S_START),
        .dividend (sum),
        .divisor  (fill),
        .quotient (quotient),
        .stat     (div_stat)
    );

    assign result_ch.valid        = out_valid_reg;
    assign result_ch.average      = average_reg;
    assign result_ch.samples_held = held_reg;
    assign result_ch.window_full  = full_reg;

endmodule

### src/wma_checker.sv
module wma_checker #(
    parameter int SAMPLE_BITS = 16
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic signed [SAMPLE_BITS-1:0] average,
    input logic [wma_pkg::LEN_W-1:0]     samples_held,
    input logic                          window_full
);
    import wma_pkg::*;

    // A stalled result keeps its valid.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result valid dropped while stalled");

    // A stalled result keeps its payload.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(average) && $stable(samples_held)
                                    && $stable(window_full))
        else $error("result payload changed while stalled");

    // A sample in flight blocks the next one.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("sample port ready right after a transaction");

    // Every average covers at least one sample.
    a_held_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> samples_held != '0)
        else $error("result with no samples held");

endmodule

bind windowed_moving_average wma_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_wma_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (sample_ch.valid),
    .in_ready     (sample_ch.ready),
    .out_valid    (result_ch.valid),
    .out_ready    (result_ch.ready),
    .average      (result_ch.average),
    .samples_held (result_ch.samples_held),
    .window_full  (result_ch.window_full)
);

### tb/windowed_moving_average_tb.sv
module windowed_moving_average_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wma_pkg::*;

    localparam int SAMPLE_BITS    = 16;
    localparam int MAX_WINDOW     = 64;
    // Hold time after the last owed mean, well past what one sample takes to a loaded result.
    localparam int DRAIN_CYCLES   = 40;
    // Cycles with no transaction on either channel before the run is abandoned.
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_ITEMS   = 95;
    localparam int IDLE_PERCENT   = 23;
    localparam int REPORT_LIMIT   = 10;

    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = 16'sh7fff;
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = 16'sh8000;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] average;
        logic [LEN_W-1:0]              held;
        logic                          full;
    } mean_result_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_wr_en;
    logic [LEN_W-1:0] cfg_wr_data;

    wma_sample_if #(.SAMPLE_BITS(SAMPLE_BITS)) sample_ch ();
    wma_result_if #(.SAMPLE_BITS(SAMPLE_BITS)) result_ch ();

    windowed_moving_average #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .sample_ch   (sample_ch),
        .result_ch   (result_ch)
    );

    // Window model: its own copy of the length register and the ring state.
    logic [LEN_W-1:0]              model_len;
    logic signed [SAMPLE_BITS-1:0] model_ring [MAX_WINDOW];
    int                            model_slot;
    int                            model_held;
    int                            model_sum;

    // Means still owed by the block, oldest first.
    mean_result_t expected_means [$];

    // Run statistics.
    bit no_idle;
    int samples_sent;
    int means_checked;
    int full_windows_seen;
    int len_writes;
    int mismatches;
    int idle_cycles;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Clear the stream state; a length write does this too.
    function automatic void restart_window();
        model_slot = 0;
        model_held = 0;
        model_sum  = 0;
    endfunction

    function automatic void load_window_len(input logic [LEN_W-1:0] len);
        model_len = len;
        restart_window();
    endfunction

    // Length as the block applies it: zero acts as one, beyond the ring as the ring.
    function automatic int active_len();
        if (model_len == '0)
            return 1;
        if (model_len > MAX_WINDOW)
            return MAX_WINDOW;
        return int'(model_len);
    endfunction

    // Add one sample to the window and form the truncated mean of what is held.
    function automatic mean_result_t window_mean(input logic signed [SAMPLE_BITS-1:0] s);
        mean_result_t res;
        int           len;
        int           mean;
        len = active_len();
        if (model_slot >= len)
            model_slot = 0;
        // Full window: the oldest sample leaves the sum as the new one lands.
        if (model_held >= len)
        begin
            model_held = len;
            model_sum  = model_sum - int'(model_ring[model_slot]);
        end
        model_ring[model_slot] = s;
        model_sum = model_sum + int'(s);
        if (model_held < len)
            model_held++;
        model_slot = (model_slot + 1 >= len) ? 0 : model_slot + 1;
        // Integer division truncates toward zero, as the block does.
        mean = model_sum / model_held;
        res.average = mean[SAMPLE_BITS-1:0];
        res.held    = model_held[LEN_W-1:0];
        res.full    = (model_held == len);
        return res;
    endfunction

    // Mix extremes, values near zero and full-range random samples.
    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(9))
            0: return SAMPLE_MAX;
            1: return SAMPLE_MIN;
            2: return $signed(16'($urandom_range(8))) - 16'sd4;
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    // Send one sample transaction; valid stays high into the next call unless a gap is taken.
    task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] s);
        if (!no_idle && $urandom_range(99) < IDLE_PERCENT)
        begin
            sample_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 32)) @(posedge clk);
        end
        sample_ch.valid  <= 1'b1;
        sample_ch.sample <= s;
        do
            @(posedge clk);
        while (!sample_ch.ready);
        expected_means.push_back(window_mean(s));
        samples_sent++;
    endtask

    // Drop valid and hold until every owed mean has come back.
    task automatic wait_for_means();
        sample_ch.valid <= 1'b0;
        while (expected_means.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    // Write the length register; only called once the block has gone idle.
    task automatic write_window_len(input logic [LEN_W-1:0] len);
        wait_for_means();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= len;
        @(posedge clk);
        load_window_len(len);
        len_writes++;
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic run_window_phase(input logic [LEN_W-1:0] len, input int count);
        write_window_len(len);
        repeat (count)
            send_sample(pick_sample());
    endtask

    // Extremes at the reset length, then the length corner cases and truncation of
    // negative means toward zero.
    task automatic test_directed();
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MIN);
        send_sample(-16'sd1);
        send_sample(16'sd0);
        send_sample(16'sd1);
        // Zero length behaves as a window of one.
        write_window_len('0);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample(-16'sd1);
        // Sum of -1 over two samples must give 0, not -1.
        write_window_len(LEN_W'(2));
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MAX);
        send_sample(-16'sd1);
        write_window_len(LEN_W'(3));
        send_sample(-16'sd1);
        send_sample(-16'sd1);
        send_sample(16'sd1);
        send_sample(-16'sd5);
        send_sample(16'sd2);
        // Every bit of the length register high: clamps to the full ring.
        write_window_len('1);
        send_sample(16'sd100);
        send_sample(-16'sd7);
    endtask

    // Saturate the full ring at both ends of the sample range and wrap it.
    task automatic test_full_scale_window();
        write_window_len(LEN_W'(MAX_WINDOW));
        repeat (MAX_WINDOW + 2)
            send_sample(SAMPLE_MIN);
        repeat (MAX_WINDOW + 2)
            send_sample(SAMPLE_MAX);
        write_window_len(LEN_W'(MAX_WINDOW + 1));
        repeat (MAX_WINDOW + 4)
            send_sample(pick_sample());
    endtask

    // Long stretch with neither side idling.
    task automatic test_back_to_back();
        no_idle = 1'b1;
        run_window_phase(LEN_W'(5), 40);
        no_idle = 1'b0;
    endtask

    // Sender holds off mid-stream until all means are in; the window must carry over.
    task automatic test_drain_midstream();
        run_window_phase(LEN_W'(7), 12);
        wait_for_means();
        repeat ($urandom_range(1, 20)) @(posedge clk);
        repeat (12)
            send_sample(pick_sample());
    endtask

    // Random lengths, mostly short so the ring wraps often, with random phase sizes.
    task automatic test_random_windows();
        logic [LEN_W-1:0] len;
        int               count;
        int               target;
        target = samples_sent + RANDOM_ITEMS;
        while (samples_sent < target)
        begin
            case ($urandom_range(9))
                0: len = '0;
                1: len = LEN_W'($urandom_range(MAX_WINDOW + 1, 127));
                2: len = LEN_W'(MAX_WINDOW);
                3: len = LEN_W'($urandom_range(17, MAX_WINDOW - 1));
                default: len = LEN_W'($urandom_range(1, 16));
            endcase
            load_window_len(model_len);
            count = $urandom_range(4, 24) + ((len == '0) ? 1 :
                    (len > MAX_WINDOW) ? MAX_WINDOW : int'(len));
            run_window_phase(len, count);
            if ($urandom_range(3) == 0)
            begin
                wait_for_means();
                repeat (8)
                    send_sample(pick_sample());
            end
        end
    endtask

    // Random receiver stalls, result checking and the watchdog, all at the rising edge.
    always @(posedge clk)
    begin
        mean_result_t got;
        mean_result_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            got.average = result_ch.average;
            got.held    = result_ch.samples_held;
            got.full    = result_ch.window_full;
            if (expected_means.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected result transaction: average %0d held %0d full %0b",
                             got.average, got.held, got.full);
            end
            else
            begin
                want = expected_means.pop_front();
                means_checked++;
                if (got.full)
                    full_windows_seen++;
                if (got.average !== want.average || got.held !== want.held ||
                    got.full !== want.full)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                    begin
                        $write("result %0d: average exp %0d got %0d,", means_checked,
                               want.average, got.average);
                        $display(" held exp %0d got %0d, full exp %0b got %0b",
                                 want.held, got.held, want.full, got.full);
                    end
                end
            end
        end
        if ((result_ch.valid && result_ch.ready) || (sample_ch.valid && sample_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("windowed_moving_average: mismatch");
            $finish;
        end
        result_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
    end

    initial
    begin
        rst_n            = 1'b0;
        cfg_wr_en        = 1'b0;
        cfg_wr_data      = '0;
        sample_ch.valid  = 1'b0;
        sample_ch.sample = '0;
        result_ch.ready  = 1'b0;
        no_idle          = 1'b0;
        // Reset value of the length register.
        load_window_len(LEN_W'(MAX_WINDOW));
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_full_scale_window();
        test_back_to_back();
        test_drain_midstream();
        test_random_windows();

        wait_for_means();
        // Hold a while longer to catch any stray result.
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_means.size() != 0)
            mismatches++;
        $display("covered %0d samples, %0d means checked, %0d with a full window",
                 samples_sent, means_checked, full_windows_seen);
        $display("%0d window length writes including zero and clamped lengths, %0d failures",
                 len_writes, mismatches);
        if (mismatches == 0)
            $display("windowed_moving_average: match");
        else
            $display("windowed_moving_average: mismatch");
        $finish;
    end

endmodule
